// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WTSP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define WTSP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define WTSP_ASSERT(label, prop)
`define WTSP_ASSERT_IMPL(label, ante, cons)
`endif
`endif

// ----- rtl/wtsp_pkg.sv -----
// Types and constants of the world-to-screen projection block
package wtsp_pkg;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned PointW  = 32;
  localparam int unsigned ProdW   = 48;
  localparam int unsigned AccW    = 50;
  localparam int unsigned FracW   = 12;
  localparam int unsigned RowW    = 38;
  localparam int unsigned NumW    = 54;
  localparam int unsigned DivW    = 38;
  localparam int unsigned QW      = 16;
  localparam int unsigned SizeW   = 14;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDatW = 48;
  localparam logic signed [RowW-1:0] NearLimit = RowW'(401);

  typedef enum logic [CfgIdxW-1:0] {
    REG_RIGHT_COEF = 4'd0,
    REG_UP_COEF    = 4'd1,
    REG_DEPTH_COEF = 4'd2,
    REG_RIGHT_OFF  = 4'd3,
    REG_UP_OFF     = 4'd4,
    REG_DEPTH_OFF  = 4'd5,
    REG_WIDTH      = 4'd6,
    REG_HEIGHT     = 4'd7
  } reg_idx_e;

  typedef struct packed {
    logic [3*CoefW-1:0]        right_coef;
    logic [3*CoefW-1:0]        up_coef;
    logic [3*CoefW-1:0]        depth_coef;
    logic signed [PointW-1:0]  right_off;
    logic signed [PointW-1:0]  up_off;
    logic signed [PointW-1:0]  depth_off;
    logic [SizeW-1:0]          width;
    logic [SizeW-1:0]          height;
  } cfg_t;

  typedef struct packed {
    logic            visible;
    logic            neg_x;
    logic            neg_y;
    logic [NumW-1:0] rem_x;
    logic [NumW-1:0] rem_y;
    logic [DivW-1:0] divisor;
    logic [QW-1:0]   q_x;
    logic [QW-1:0]   q_y;
  } div_t;
endpackage

// ----- rtl/wtsp_if.sv -----
// Channel interfaces: points in, screen results out, register writes
interface wtsp_point_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  point_x;
  logic signed [31:0]  point_y;
  logic signed [31:0]  point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface wtsp_result_if;
  logic                valid;
  logic                ready;
  logic                visible;
  logic signed [15:0]  screen_x;
  logic signed [15:0]  screen_y;
  modport source (output valid, visible, screen_x, screen_y, input ready);
  modport sink   (input valid, visible, screen_x, screen_y, output ready);
endinterface

interface wtsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/wtsp_front.sv -----
// Front stages: row products, row sums with offsets, scaled numerators
module wtsp_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  wtsp_pkg::cfg_t                   cfg_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [wtsp_pkg::PointW-1:0] p0_i,
  input  logic signed [wtsp_pkg::PointW-1:0] p1_i,
  input  logic signed [wtsp_pkg::PointW-1:0] p2_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output wtsp_pkg::div_t                   out_o
);
  import wtsp_pkg::*;

  logic                     va_q, vb_q, vc_q;
  logic                     ena, enb, enc;
  logic signed [ProdW-1:0]  prod_q [3][3];
  logic signed [ProdW-1:0]  prod_d [3][3];
  logic signed [RowW-1:0]   row_q [3];
  logic signed [RowW-1:0]   row_d [3];
  logic [3*CoefW-1:0]       coef [3];
  logic signed [PointW-1:0] off [3];
  logic signed [PointW-1:0] pt [3];
  logic signed [AccW-1:0]   acc [3];
  logic signed [RowW:0]     sum_x, dif_y;
  logic signed [NumW-1:0]   num_x, num_y;
  div_t                     div_d, div_q;

  assign enc = !vc_q || out_ready_i;
  assign enb = !vb_q || enc;
  assign ena = !va_q || enb;
  assign in_ready_o = ena;

  // row 0 right, row 1 up, row 2 depth
  assign coef[0] = cfg_i.right_coef;
  assign coef[1] = cfg_i.up_coef;
  assign coef[2] = cfg_i.depth_coef;
  assign off[0]  = cfg_i.right_off;
  assign off[1]  = cfg_i.up_off;
  assign off[2]  = cfg_i.depth_off;
  assign pt[0]   = p0_i;
  assign pt[1]   = p1_i;
  assign pt[2]   = p2_i;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[r][j] = ProdW'($signed(coef[r][CoefW*j +: CoefW])) * ProdW'(pt[j]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = AccW'(prod_q[r][0]) + AccW'(prod_q[r][1]) + AccW'(prod_q[r][2])
             + (AccW'(off[r]) <<< FracW);
      // arithmetic shift floors toward minus infinity
      row_d[r] = RowW'(acc[r] >>> FracW);
    end
  end

  always_comb begin
    sum_x = (RowW+1)'(row_q[2]) + (RowW+1)'(row_q[0]);
    dif_y = (RowW+1)'(row_q[2]) - (RowW+1)'(row_q[1]);
    num_x = NumW'($signed({1'b0, cfg_i.width})) * NumW'(sum_x);
    num_y = NumW'($signed({1'b0, cfg_i.height})) * NumW'(dif_y);
    div_d.visible = row_q[2] >= NearLimit;
    div_d.neg_x   = num_x[NumW-1];
    div_d.neg_y   = num_y[NumW-1];
    // fold negatives: floor(n/d) = ~floor(~n/d)
    div_d.rem_x   = num_x[NumW-1] ? ~num_x : num_x;
    div_d.rem_y   = num_y[NumW-1] ? ~num_y : num_y;
    div_d.divisor = {row_q[2][DivW-2:0], 1'b0};
    div_d.q_x     = '0;
    div_d.q_y     = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (ena) va_q <= in_valid_i;
      if (enb) vb_q <= va_q;
      if (enc) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ena) prod_q <= prod_d;
    if (enb) row_q  <= row_d;
    if (enc) div_q  <= div_d;
  end

  assign out_valid_o = vc_q;
  assign out_o       = div_q;
endmodule

// ----- rtl/wtsp_div_cell.sv -----
// One restoring-division cell: settles one quotient bit for both lanes
module wtsp_div_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  wtsp_pkg::div_t  in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output wtsp_pkg::div_t  out_o
);
  import wtsp_pkg::*;

  logic            valid_q;
  div_t            data_d, data_q;
  logic [NumW:0]   step, trial_x, trial_y;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    step    = (NumW+1)'(in_i.divisor) << SHIFT;
    trial_x = {1'b0, in_i.rem_x} - step;
    trial_y = {1'b0, in_i.rem_y} - step;
    data_d  = in_i;
    if (!trial_x[NumW]) begin
      data_d.rem_x      = trial_x[NumW-1:0];
      data_d.q_x[SHIFT] = 1'b1;
    end
    if (!trial_y[NumW]) begin
      data_d.rem_y      = trial_y[NumW-1:0];
      data_d.q_y[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;
endmodule

// ----- rtl/world_to_screen_projection.sv -----
// Top level: register file, front stages, division cell row, output register
// Projects one point per clock cycle once the pipe is primed, while results
// are taken: three row dot products (9 parallel 32x16 multipliers), the row
// sums and two scaled numerators take three stages, then a row of 16 division
// cells settles one quotient bit per cell, and an output register holds the
// result. Each stage advances when the stage after it is free, so bubbles
// collapse and new points keep entering while a finished result waits.
// Register writes are never stalled.
module world_to_screen_projection (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  wtsp_point_if.sink           pt_i,
  wtsp_result_if.source        res_o,
  wtsp_cfg_if.sink             cfg_i
);
  import wtsp_pkg::*;
  `include "assert_macros.svh"

  cfg_t  cfg_q;
  logic  cv [QW+1];
  logic  cr [QW+1];
  div_t  cd [QW+1];
  logic  out_valid_q, out_en;
  logic  visible_q;
  logic signed [QW-1:0] sx_q, sy_q, sx_d, sy_d;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.right_coef <= '0;
      cfg_q.up_coef    <= '0;
      cfg_q.depth_coef <= '0;
      cfg_q.right_off  <= '0;
      cfg_q.up_off     <= '0;
      cfg_q.depth_off  <= PointW'(4096);
      cfg_q.width      <= SizeW'(1920);
      cfg_q.height     <= SizeW'(1080);
    end else if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_RIGHT_COEF: cfg_q.right_coef <= cfg_i.data;
        REG_UP_COEF:    cfg_q.up_coef    <= cfg_i.data;
        REG_DEPTH_COEF: cfg_q.depth_coef <= cfg_i.data;
        REG_RIGHT_OFF:  cfg_q.right_off  <= cfg_i.data[PointW-1:0];
        REG_UP_OFF:     cfg_q.up_off     <= cfg_i.data[PointW-1:0];
        REG_DEPTH_OFF:  cfg_q.depth_off  <= cfg_i.data[PointW-1:0];
        REG_WIDTH:      cfg_q.width      <= cfg_i.data[SizeW-1:0];
        REG_HEIGHT:     cfg_q.height     <= cfg_i.data[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // world y and z swap places
  wtsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (pt_i.valid),
    .in_ready_o  (pt_i.ready),
    .p0_i        (pt_i.point_x),
    .p1_i        (pt_i.point_z),
    .p2_i        (pt_i.point_y),
    .out_valid_o (cv[0]),
    .out_ready_i (cr[0]),
    .out_o       (cd[0])
  );

  for (genvar k = 0; k < QW; k++) begin : g_cell
    wtsp_div_cell #(.SHIFT(QW-1-k)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (cv[k]),
      .in_ready_o  (cr[k]),
      .in_i        (cd[k]),
      .out_valid_o (cv[k+1]),
      .out_ready_i (cr[k+1]),
      .out_o       (cd[k+1])
    );
  end

  assign out_en   = !out_valid_q || res_o.ready;
  assign cr[QW]   = out_en;

  // top quotient bit set means the magnitude is past 15 bits: saturate
  always_comb begin
    if (cd[QW].q_x[QW-1]) begin
      sx_d = cd[QW].neg_x ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    end else begin
      sx_d = cd[QW].neg_x ? ~{1'b0, cd[QW].q_x[QW-2:0]} : {1'b0, cd[QW].q_x[QW-2:0]};
    end
    if (cd[QW].q_y[QW-1]) begin
      sy_d = cd[QW].neg_y ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    end else begin
      sy_d = cd[QW].neg_y ? ~{1'b0, cd[QW].q_y[QW-2:0]} : {1'b0, cd[QW].q_y[QW-2:0]};
    end
    if (!cd[QW].visible) begin
      sx_d = '0;
      sy_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= cv[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      visible_q <= cd[QW].visible;
      sx_q      <= sx_d;
      sy_q      <= sy_d;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.visible  = visible_q;
  assign res_o.screen_x = sx_q;
  assign res_o.screen_y = sy_q;

  `WTSP_ASSERT_IMPL(a_hidden_zero, out_valid_q && !visible_q, sx_q == '0 && sy_q == '0)
  `WTSP_ASSERT_IMPL(a_full_when_blocked, !pt_i.ready, out_valid_q && !res_o.ready)
  `WTSP_ASSERT(a_accept_enters, pt_i.valid && pt_i.ready |=> u_front.va_q)
endmodule
